### design/cpu_load_max_monitor_top_assert.svh
// assertion helpers shared by the monitor rtl
`ifndef CPU_LOAD_MAX_MONITOR_TOP_ASSERT_SVH
`define CPU_LOAD_MAX_MONITOR_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CLMM_AST_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CLMM_AST_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/clmm_pkg.sv
package clmm_pkg;

  localparam int CPU_SLOTS_DEF = 8;
  localparam int SLOT_IN_W     = 3;
  localparam int TIME_W        = 64;
  localparam int LOAD_W        = 7;
  // product busy*100 fits 71 bits, one more for the borrow-free compare
  localparam int ACC_W         = TIME_W + LOAD_W + 1;
  localparam int STEP_W        = 3;

  localparam logic [LOAD_W-1:0] LOAD_FULL = LOAD_W'(100);
  localparam logic [STEP_W-1:0] DIV_TOP   = STEP_W'(LOAD_W - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOT,
    S_IDL,
    S_BUSY,
    S_M1,
    S_M2,
    S_DIV,
    S_FIN
  } clmm_state_t;

  // samp_we: item taken, write the new sample and read the old slot state
  // load_we: write the finished load back to the slot
  typedef struct packed {
    logic samp_we;
    logic load_we;
  } clmm_mem_cmd_t;

  typedef struct packed {
    logic              valid;
    logic [LOAD_W-1:0] load;
    logic              pass_end;
  } clmm_res_t;

  // slot index modulo the slot count, by repeated subtraction
  function automatic logic [SLOT_IN_W-1:0] slot_reduce(input logic [SLOT_IN_W-1:0] s,
                                                        input int unsigned n);
    logic [SLOT_IN_W-1:0] r;
    r = s;
    for (int i = 0; i < (1 << SLOT_IN_W) - 1; i++) begin
      if (n < (1 << SLOT_IN_W) && 32'(r) >= n) begin
        r = r - SLOT_IN_W'(n);
      end
    end
    return r;
  endfunction

endpackage

### design/clmm_alu.sv
module clmm_alu
  import clmm_pkg::*;
(
  input  logic [ACC_W-1:0] a,
  input  logic [ACC_W-1:0] b,
  input  logic             sub,
  output logic [ACC_W-1:0] sum,
  output logic             borrow
);

  logic [ACC_W:0] ext;

  // one adder: a + b, or a + ~b + 1 with carry out as not-borrow
  assign ext = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (ACC_W + 1)'(sub);
  assign sum    = ext[ACC_W-1:0];
  assign borrow = sub & ~ext[ACC_W];

endmodule

### design/clmm_slot_mem.sv
module clmm_slot_mem
  import clmm_pkg::*;
#(
  parameter int CPU_SLOTS = CPU_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  clmm_mem_cmd_t       cmd,
  input  logic [((CPU_SLOTS > 1) ? $clog2(CPU_SLOTS) : 1)-1:0] addr,
  input  logic [TIME_W-1:0]   wr_idle,
  input  logic [TIME_W-1:0]   wr_wall,
  input  logic [LOAD_W-1:0]   wr_load,
  output logic [TIME_W-1:0]   rd_idle,
  output logic [TIME_W-1:0]   rd_wall,
  output logic [LOAD_W-1:0]   rd_load
);

  logic [TIME_W-1:0] idle_mem [CPU_SLOTS];
  logic [TIME_W-1:0] wall_mem [CPU_SLOTS];
  logic [LOAD_W-1:0] load_mem [CPU_SLOTS];
  logic [CPU_SLOTS-1:0] samp_vld;
  logic [CPU_SLOTS-1:0] load_vld;

  logic [TIME_W-1:0] idle_raw;
  logic [TIME_W-1:0] wall_raw;
  logic [LOAD_W-1:0] load_raw;
  logic              samp_hit;
  logic              load_hit;

  always_ff @(posedge clk) begin
    if (cmd.samp_we) begin
      idle_mem[addr] <= wr_idle;
      wall_mem[addr] <= wr_wall;
      idle_raw       <= idle_mem[addr];
      wall_raw       <= wall_mem[addr];
      load_raw       <= load_mem[addr];
    end
    if (cmd.load_we) begin
      load_mem[addr] <= wr_load;
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      samp_vld <= '0;
      load_vld <= '0;
      samp_hit <= 1'b0;
      load_hit <= 1'b0;
    end else begin
      if (cmd.samp_we) begin
        samp_hit       <= samp_vld[addr];
        load_hit       <= load_vld[addr];
        samp_vld[addr] <= 1'b1;
      end
      if (cmd.load_we) begin
        load_vld[addr] <= 1'b1;
      end
    end
  end

  assign rd_idle = samp_hit ? idle_raw : '0;
  assign rd_wall = samp_hit ? wall_raw : '0;
  assign rd_load = load_hit ? load_raw : '0;

endmodule

### design/clmm_ctrl.sv
`include "cpu_load_max_monitor_top_assert.svh"

module clmm_ctrl
  import clmm_pkg::*;
#(
  parameter int CPU_SLOTS = CPU_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SLOT_IN_W-1:0] cpu_slot,
  input  logic [TIME_W-1:0]    idle_time_us,
  input  logic [TIME_W-1:0]    wall_time_us,
  input  logic                 pass_end,
  output clmm_mem_cmd_t        mem_cmd,
  output logic [((CPU_SLOTS > 1) ? $clog2(CPU_SLOTS) : 1)-1:0] mem_addr,
  output logic [LOAD_W-1:0]    mem_wr_load,
  input  logic [TIME_W-1:0]    mem_rd_idle,
  input  logic [TIME_W-1:0]    mem_rd_wall,
  input  logic [LOAD_W-1:0]    mem_rd_load,
  output logic [ACC_W-1:0]     alu_a,
  output logic [ACC_W-1:0]     alu_b,
  output logic                 alu_sub,
  input  logic [ACC_W-1:0]     alu_sum,
  input  logic                 alu_borrow,
  output clmm_res_t            res,
  input  logic                 res_free
);

  localparam int SLOT_W = (CPU_SLOTS > 1) ? $clog2(CPU_SLOTS) : 1;

  clmm_state_t state, state_next;

  logic [SLOT_W-1:0]    slot_q;
  logic [TIME_W-1:0]    idle_q;
  logic [TIME_W-1:0]    wall_q;
  logic                 end_q;
  logic [TIME_W-1:0]    total;
  logic [TIME_W-1:0]    busy;
  logic [ACC_W-1:0]     acc;
  logic [LOAD_W-1:0]    quo;
  logic [STEP_W-1:0]    step;
  logic                 zero_tot;

  logic [SLOT_IN_W-1:0] slot_red;
  logic [SLOT_W-1:0]    slot_in;
  logic                 accept;
  logic [LOAD_W-1:0]    load_fin;

  assign slot_red = slot_reduce(cpu_slot, CPU_SLOTS);
  assign slot_in  = SLOT_W'(slot_red);
  assign accept   = in_valid && !in_stall;
  assign load_fin = zero_tot ? mem_rd_load : ((quo > LOAD_FULL) ? LOAD_FULL : quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_TOT;
      S_TOT:  state_next = S_IDL;
      S_IDL:  state_next = S_BUSY;
      S_BUSY: state_next = (total == '0) ? S_FIN : S_M1;
      S_M1:   state_next = S_M2;
      S_M2:   state_next = S_DIV;
      S_DIV:  if (step == '0) state_next = S_FIN;
      S_FIN:  if (res_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall        = 1'b1;
    mem_cmd.samp_we = 1'b0;
    mem_cmd.load_we = 1'b0;
    mem_addr        = slot_q;
    mem_wr_load     = load_fin;
    alu_a           = '0;
    alu_b           = '0;
    alu_sub         = 1'b1;
    res.valid       = 1'b0;
    res.load        = load_fin;
    res.pass_end    = end_q;
    case (state)
      S_IDLE: begin
        in_stall        = 1'b0;
        mem_addr        = slot_in;
        mem_cmd.samp_we = in_valid;
      end
      S_TOT: begin
        alu_a = ACC_W'(wall_q);
        alu_b = ACC_W'(mem_rd_wall);
      end
      S_IDL: begin
        alu_a = ACC_W'(idle_q);
        alu_b = ACC_W'(mem_rd_idle);
      end
      S_BUSY: begin
        alu_a = ACC_W'(total);
        alu_b = ACC_W'(busy);
      end
      S_M1: begin
        // busy*64 + busy*32
        alu_sub = 1'b0;
        alu_a   = ACC_W'(busy) << 6;
        alu_b   = ACC_W'(busy) << 5;
      end
      S_M2: begin
        // + busy*4
        alu_sub = 1'b0;
        alu_a   = acc;
        alu_b   = ACC_W'(busy) << 2;
      end
      S_DIV: begin
        alu_a = acc;
        alu_b = ACC_W'(total) << step;
      end
      S_FIN: begin
        res.valid       = 1'b1;
        mem_cmd.load_we = res_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          slot_q <= slot_in;
          idle_q <= idle_time_us;
          wall_q <= wall_time_us;
          end_q  <= pass_end;
        end
      end
      S_TOT: total <= alu_sum[TIME_W-1:0];
      S_IDL: busy  <= alu_sum[TIME_W-1:0];
      S_BUSY: begin
        busy     <= alu_borrow ? '0 : alu_sum[TIME_W-1:0];
        zero_tot <= (total == '0);
      end
      S_M1: begin
        acc  <= alu_sum;
        quo  <= '0;
        step <= DIV_TOP;
      end
      S_M2: acc <= alu_sum;
      S_DIV: begin
        if (!alu_borrow) begin
          acc <= alu_sum;
        end
        quo  <= {quo[LOAD_W-2:0], ~alu_borrow};
        step <= step - STEP_W'(1);
      end
      default: ;
    endcase
  end

  `CLMM_AST_NXT(a_accept_starts, accept, state == S_TOT, "accepted item did not start work")
  `CLMM_AST_IMP(a_busy_le_total, state == S_M1, busy <= total, "busy delta above total")
  `CLMM_AST_IMP(a_quo_bounded, state == S_FIN && !zero_tot, quo <= LOAD_FULL,
                "quotient above full load")

endmodule

### design/cpu_load_max_monitor_top.sv
// per-cpu load monitor: each item is one sample of a cpu slot (cumulative idle
// and wall microseconds) and gives one result, the slot's load in percent
// (0..100) and the highest load of the current polling pass; pass_end marks the
// last sample of a pass, its result carries pass_done and the pass maximum then
// starts over from zero. the load is floor(busy*100/total) on the 64-bit deltas
// against the slot's previous sample; a zero wall delta repeats the slot's last
// load, idle beyond wall counts as no busy time. each item runs through the
// deltas, the busy*100 product and a seven-step restoring divide (product and
// divide are skipped when no wall time passed), all on one shared 72-bit
// adder under a small sequencer, and no new item is taken until the result
// has moved into the output register. that register lets the next item start
// while a result still waits on out_stall.
`include "cpu_load_max_monitor_top_assert.svh"

module cpu_load_max_monitor_top
  import clmm_pkg::*;
#(
  parameter int CPU_SLOTS = CPU_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SLOT_IN_W-1:0] cpu_slot,
  input  logic [TIME_W-1:0]    idle_time_us,
  input  logic [TIME_W-1:0]    wall_time_us,
  input  logic                 pass_end,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [LOAD_W-1:0]    slot_load,
  output logic [LOAD_W-1:0]    max_load,
  output logic                 pass_done
);

  localparam int SLOT_W = (CPU_SLOTS > 1) ? $clog2(CPU_SLOTS) : 1;

  // slot state storage
  clmm_mem_cmd_t     mem_cmd;
  logic [SLOT_W-1:0] mem_addr;
  logic [LOAD_W-1:0] mem_wr_load;
  logic [TIME_W-1:0] mem_rd_idle;
  logic [TIME_W-1:0] mem_rd_wall;
  logic [LOAD_W-1:0] mem_rd_load;

  // shared adder
  logic [ACC_W-1:0]  alu_a;
  logic [ACC_W-1:0]  alu_b;
  logic              alu_sub;
  logic [ACC_W-1:0]  alu_sum;
  logic              alu_borrow;

  // finished load from the sequencer
  clmm_res_t         res;
  logic              res_free;

  // running maximum of the pass
  logic [LOAD_W-1:0] pass_max;
  logic [LOAD_W-1:0] mx;

  clmm_slot_mem #(
    .CPU_SLOTS (CPU_SLOTS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .cmd     (mem_cmd),
    .addr    (mem_addr),
    .wr_idle (idle_time_us),
    .wr_wall (wall_time_us),
    .wr_load (mem_wr_load),
    .rd_idle (mem_rd_idle),
    .rd_wall (mem_rd_wall),
    .rd_load (mem_rd_load)
  );

  clmm_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .sum    (alu_sum),
    .borrow (alu_borrow)
  );

  clmm_ctrl #(
    .CPU_SLOTS (CPU_SLOTS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cpu_slot     (cpu_slot),
    .idle_time_us (idle_time_us),
    .wall_time_us (wall_time_us),
    .pass_end     (pass_end),
    .mem_cmd      (mem_cmd),
    .mem_addr     (mem_addr),
    .mem_wr_load  (mem_wr_load),
    .mem_rd_idle  (mem_rd_idle),
    .mem_rd_wall  (mem_rd_wall),
    .mem_rd_load  (mem_rd_load),
    .alu_a        (alu_a),
    .alu_b        (alu_b),
    .alu_sub      (alu_sub),
    .alu_sum      (alu_sum),
    .alu_borrow   (alu_borrow),
    .res          (res),
    .res_free     (res_free)
  );

  // output register is free when empty or being taken this cycle
  assign res_free = !out_valid || !out_stall;
  assign mx       = (res.load > pass_max) ? res.load : pass_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pass_max  <= '0;
    end else if (res.valid && res_free) begin
      out_valid <= 1'b1;
      // a pass ends with this item: the next pass starts from zero
      pass_max  <= res.pass_end ? '0 : mx;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_free) begin
      slot_load <= res.load;
      max_load  <= mx;
      pass_done <= res.pass_end;
    end
  end

  `CLMM_AST_IMP(a_max_covers_slot, out_valid, max_load >= slot_load,
                "pass maximum below slot load")

endmodule
